/* design/pbe_pkg.sv */
// Shared types and constants for the piecewise Bezier easing evaluator.
package pbe_pkg;

   // Item operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   // Graph units per 1.0, a power of two so the final scaling is a shift
   localparam int GRAPH_SHIFT      = 12;
   localparam int GRAPH_RESOLUTION = 1 << GRAPH_SHIFT;

   // Signed width of the scaled value before the final shift
   localparam int QW = 51;

   // One control point as stored in the table
   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] lx;
      logic signed [15:0] ly;
      logic signed [15:0] rx;
      logic signed [15:0] ry;
   } point_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD0,
      ST_SRCH,
      ST_T2,
      ST_S2,
      ST_B0,
      ST_B1,
      ST_B2,
      ST_B3,
      ST_ACC,
      ST_CMP,
      ST_DH,
      ST_DL,
      ST_DIV,
      ST_FIN
   } state_type;

endpackage

/* design/pbe_div.sv */
// Floor division of a signed value by the graph resolution, as a registered shift.
module pbe_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [pbe_pkg::QW-1:0]  dividend,
   output logic                           done,
   output logic signed [pbe_pkg::QW-1:0]  quotient
);

   logic                          done_ff;
   logic signed [pbe_pkg::QW-1:0] quot_ff;

   // done strobe in the cycle after start
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   // arithmetic shift rounds toward minus infinity
   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend >>> pbe_pkg::GRAPH_SHIFT;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

/* design/piecewise_bezier_easing_eval.sv */
// Top level of the piecewise cubic Bezier easing curve evaluator.
// A point write goes into the table as it is accepted. An evaluation is run by
// a sequencer around one shared 34x32 multiplier: the item is taken, the first
// table entry is read, the segments are tried in turn (the table is read one
// entry a cycle), then each bisection step runs six weight products, four
// accumulate products and a compare, the final y runs the weight and
// accumulate products once more, two products scale it (DH, DL), the result is
// shifted by the graph resolution and then loaded, showing in the same cycle
// as the block is ready again. A ratio above one or a table with fewer than
// two points goes straight to the load with found low, as does a search that
// finds no segment. The block takes no item while it works, and it also holds
// in its last state while an earlier result has not been taken; the result
// sits in an output register, so a new item may come in while it waits to be
// taken.
module piecewise_bezier_easing_eval #(
   parameter int MAX_POINTS       = 64,
   parameter int BISECT_STEPS     = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic [5:0]          req_point_index,
   input  logic                req_is_last_point,
   input  logic signed [15:0]  req_center_x,
   input  logic signed [15:0]  req_center_y,
   input  logic signed [15:0]  req_left_x,
   input  logic signed [15:0]  req_left_y,
   input  logic signed [15:0]  req_right_x,
   input  logic signed [15:0]  req_right_y,
   input  logic [16:0]         req_progress,
   input  logic signed [31:0]  req_start_value,
   input  logic signed [31:0]  req_end_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_curve_value,
   output logic                rsp_found
);

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int IXW  = ((AW > 6) ? AW : 6) + 1;
   localparam int KW   = ((AW + 1) > 8) ? (AW + 1) : 8;
   localparam int SW   = $clog2(BISECT_STEPS + 1);
   localparam int QW   = pbe_pkg::QW;
   localparam logic [30:0] TONE = 31'h4000_0000;

   // point table
   pbe_pkg::point_type mem [MAX_POINTS];
   pbe_pkg::point_type rd_ff;
   logic [AW-1:0]      rd_addr;
   logic [IXW-1:0]     idx_w;
   logic               idx_ok;
   logic               wr_en;

   pbe_pkg::state_type state_ff, state_in;
   logic [6:0]         count_ff;
   logic [AW-1:0]      k_ff;
   pbe_pkg::point_type a_ff, c_ff;
   logic signed [33:0] pr_ff;
   logic signed [31:0] st_ff;
   logic signed [32:0] d_ff;
   logic signed [55:0] n_ff;
   logic signed [16:0] hx1_ff, hx2_ff, dx_ff;
   logic [30:0]        t_ff, tl_ff, tr_ff, t2_ff, s2_ff;
   logic [32:0]        b_ff [4];
   logic signed [55:0] acc_ff;
   logic [1:0]         ki_ff;
   logic [SW-1:0]      step_ff;
   logic               ycalc_ff;
   logic               found_ff;
   logic signed [QW-1:0] q_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_found_ff;

   logic               accept;
   logic [KW-1:0]      count_ext, cnt, kp1;
   logic signed [33:0] lo_a, lo_c;
   logic               hit;
   logic [30:0]        s;
   logic signed [33:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [65:0] prod;
   logic [30:0]        psh;
   logic [32:0]        ptri;
   logic signed [31:0] coef;
   logic signed [QW-1:0] q_in;
   logic               div_start;
   logic               div_done;
   logic signed [QW-1:0] quot;
   logic signed [QW:0] fin_sum;
   logic signed [31:0] fin_val;
   logic               load_rsp;
   logic [31:0]        t_sum_lo, t_sum_hi;

   assign accept = req_valid && req_ready;
   assign idx_w  = IXW'(req_point_index);
   assign idx_ok = idx_w < IXW'(MAX_POINTS);
   assign wr_en  = accept && req_operation == pbe_pkg::OP_WRITE && idx_ok;

   // table write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_w[AW-1:0]] <= '{cx: req_center_x, cy: req_center_y,
                                 lx: req_left_x,   ly: req_left_y,
                                 rx: req_right_x,  ry: req_right_y};
      end
      rd_ff <= mem[rd_addr];
   end

   // search helpers
   always_comb begin
      count_ext = KW'(count_ff);
      cnt       = (count_ext > KW'(MAX_POINTS)) ? KW'(MAX_POINTS) : count_ext;
      kp1       = KW'(k_ff) + KW'(1);
      lo_a      = {{2{a_ff.cx[15]}}, a_ff.cx, 16'h0000};
      lo_c      = {{2{rd_ff.cx[15]}}, rd_ff.cx, 16'h0000};
      hit       = (pr_ff >= lo_a) && (pr_ff <= lo_c);
      s         = TONE - t_ff;
   end

   // accumulate coefficient: x handle offsets or y coordinates
   always_comb begin
      unique case (ki_ff)
         2'd0: coef = ycalc_ff ? 32'(a_ff.cy) : 32'sd0;
         2'd1: coef = ycalc_ff ? 32'(a_ff.ry) : 32'(hx1_ff);
         2'd2: coef = ycalc_ff ? 32'(c_ff.ly) : 32'(hx2_ff);
         default: coef = ycalc_ff ? 32'(c_ff.cy) : 32'(dx_ff);
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         pbe_pkg::ST_T2: begin
            mul_a = $signed({3'b000, t_ff});
            mul_b = $signed({1'b0, t_ff});
         end
         pbe_pkg::ST_S2: begin
            mul_a = $signed({3'b000, s});
            mul_b = $signed({1'b0, s});
         end
         pbe_pkg::ST_B0: begin
            mul_a = $signed({3'b000, s2_ff});
            mul_b = $signed({1'b0, s});
         end
         pbe_pkg::ST_B1: begin
            mul_a = $signed({3'b000, t_ff});
            mul_b = $signed({1'b0, s2_ff});
         end
         pbe_pkg::ST_B2: begin
            mul_a = $signed({3'b000, t2_ff});
            mul_b = $signed({1'b0, s});
         end
         pbe_pkg::ST_B3: begin
            mul_a = $signed({3'b000, t2_ff});
            mul_b = $signed({1'b0, t_ff});
         end
         pbe_pkg::ST_ACC: begin
            mul_a = $signed({1'b0, b_ff[ki_ff]});
            mul_b = coef;
         end
         pbe_pkg::ST_DH: begin
            // integer part of the y sum, signed
            mul_a = 34'(d_ff);
            mul_b = 32'($signed(acc_ff[55:30]));
         end
         pbe_pkg::ST_DL: begin
            mul_a = 34'(d_ff);
            mul_b = $signed({2'b00, acc_ff[29:0]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      prod     = mul_a * mul_b;
      psh      = prod[60:30];
      ptri     = {2'b00, psh} + {1'b0, psh, 1'b0};
      q_in     = q_ff + QW'($signed(prod[65:30]));
      t_sum_lo = {1'b0, tl_ff} + {1'b0, t_ff};
      t_sum_hi = {1'b0, t_ff} + {1'b0, tr_ff};
   end

   // final value, saturated, zero when no segment was found
   always_comb begin
      fin_sum = (QW+1)'(st_ff) + (QW+1)'(quot);
      if (!found_ff) begin
         fin_val = '0;
      end else if (fin_sum > (QW+1)'(32'sh7fff_ffff)) begin
         fin_val = 32'sh7fff_ffff;
      end else if (fin_sum < -(QW+1)'(64'sh8000_0000)) begin
         fin_val = 32'sh8000_0000;
      end else begin
         fin_val = fin_sum[31:0];
      end
   end

   // sequencer: next state and strobes
   always_comb begin
      state_in  = state_ff;
      req_ready = state_ff == pbe_pkg::ST_IDLE;
      rd_addr   = k_ff;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         pbe_pkg::ST_IDLE: begin
            rd_addr = '0;
            if (accept && req_operation == pbe_pkg::OP_EVAL) begin
               if (req_progress > 17'd65536 || cnt < KW'(2)) begin
                  state_in = pbe_pkg::ST_FIN;
               end else begin
                  state_in = pbe_pkg::ST_RD0;
               end
            end
         end
         pbe_pkg::ST_RD0: begin
            rd_addr  = AW'(1);
            state_in = pbe_pkg::ST_SRCH;
         end
         pbe_pkg::ST_SRCH: begin
            rd_addr = kp1[AW-1:0];
            if (hit) begin
               state_in = pbe_pkg::ST_T2;
            end else if (kp1 >= cnt) begin
               state_in = pbe_pkg::ST_FIN;
            end
         end
         pbe_pkg::ST_T2:  state_in = pbe_pkg::ST_S2;
         pbe_pkg::ST_S2:  state_in = pbe_pkg::ST_B0;
         pbe_pkg::ST_B0:  state_in = pbe_pkg::ST_B1;
         pbe_pkg::ST_B1:  state_in = pbe_pkg::ST_B2;
         pbe_pkg::ST_B2:  state_in = pbe_pkg::ST_B3;
         pbe_pkg::ST_B3:  state_in = pbe_pkg::ST_ACC;
         pbe_pkg::ST_ACC: begin
            if (ki_ff == 2'd3) begin
               state_in = ycalc_ff ? pbe_pkg::ST_DH : pbe_pkg::ST_CMP;
            end
         end
         pbe_pkg::ST_CMP: state_in = pbe_pkg::ST_T2;
         pbe_pkg::ST_DH:  state_in = pbe_pkg::ST_DL;
         pbe_pkg::ST_DL: begin
            div_start = 1'b1;
            state_in  = pbe_pkg::ST_DIV;
         end
         pbe_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = pbe_pkg::ST_FIN;
            end
         end
         pbe_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = pbe_pkg::ST_IDLE;
            end
         end
         default: state_in = pbe_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbe_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (wr_en && req_is_last_point) begin
            count_ff <= 7'(req_point_index) + 7'd1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_value_ff <= fin_val;
         rsp_found_ff <= found_ff;
      end
      unique case (state_ff)
         pbe_pkg::ST_IDLE: begin
            if (accept) begin
               pr_ff    <= 34'(req_progress) * 34'(pbe_pkg::GRAPH_RESOLUTION);
               st_ff    <= req_start_value;
               d_ff     <= 33'(req_end_value) - 33'(req_start_value);
               found_ff <= 1'b0;
            end
         end
         pbe_pkg::ST_RD0: begin
            a_ff <= rd_ff;
            k_ff <= AW'(1);
         end
         pbe_pkg::ST_SRCH: begin
            if (hit) begin
               c_ff     <= rd_ff;
               found_ff <= 1'b1;
               n_ff     <= 56'(pr_ff - lo_a) <<< 14;
               hx1_ff   <= 17'(a_ff.rx) - 17'(a_ff.cx);
               hx2_ff   <= 17'(rd_ff.lx) - 17'(a_ff.cx);
               dx_ff    <= 17'(rd_ff.cx) - 17'(a_ff.cx);
               t_ff     <= TONE >> 1;
               tl_ff    <= '0;
               tr_ff    <= TONE;
               step_ff  <= '0;
               ycalc_ff <= 1'b0;
            end else begin
               a_ff <= rd_ff;
               k_ff <= kp1[AW-1:0];
            end
         end
         pbe_pkg::ST_T2: t2_ff <= psh;
         pbe_pkg::ST_S2: s2_ff <= psh;
         pbe_pkg::ST_B0: b_ff[0] <= {2'b00, psh};
         pbe_pkg::ST_B1: b_ff[1] <= ptri;
         pbe_pkg::ST_B2: b_ff[2] <= ptri;
         pbe_pkg::ST_B3: begin
            b_ff[3] <= {2'b00, psh};
            acc_ff  <= '0;
            ki_ff   <= '0;
         end
         pbe_pkg::ST_ACC: begin
            acc_ff <= acc_ff + prod[55:0];
            ki_ff  <= ki_ff + 2'd1;
         end
         pbe_pkg::ST_CMP: begin
            // bisection step on t
            if (n_ff < acc_ff) begin
               tr_ff <= t_ff;
               t_ff  <= t_sum_lo[31:1];
            end else begin
               tl_ff <= t_ff;
               t_ff  <= t_sum_hi[31:1];
            end
            step_ff <= step_ff + SW'(1);
            if (step_ff == SW'(BISECT_STEPS - 1)) begin
               ycalc_ff <= 1'b1;
            end
         end
         pbe_pkg::ST_DH: q_ff <= prod[QW-1:0];
         default: begin
         end
      endcase
   end

   pbe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (q_in),
      .done     (div_done),
      .quotient (quot)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_curve_value = rsp_value_ff;
   assign rsp_found       = rsp_found_ff;

endmodule

/* verif/piecewise_bezier_easing_eval_test.sv */
// Self-checking testbench for the piecewise Bezier easing curve evaluator.
`timescale 1ns / 1ps

module piecewise_bezier_easing_eval_test;

   localparam int  ITEM_TARGET = 800;
   localparam int  CYCLE_LIMIT = 1500000;
   localparam int  TAIL_CYCLES = 400;
   localparam int  UNITY       = 65536;
   localparam int  GRES        = pbe_pkg::GRAPH_RESOLUTION;
   localparam int  STEPS       = 10;
   localparam longint unsigned T_ONE = 64'd1 << 30;

   // One input transfer plus its pacing controls
   typedef struct {
      logic               op;
      logic [5:0]         idx;
      logic               last;
      logic signed [15:0] cx, cy, lx, ly, rx, ry;
      logic [16:0]        prog;
      logic signed [31:0] st, ed;
      int                 gap;
      bit                 drain;
   } curve_req_type;

   typedef struct {
      logic signed [31:0] value;
      logic               found;
   } curve_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_operation = pbe_pkg::OP_WRITE;
   logic [5:0]         req_point_index = '0;
   logic               req_is_last_point = 1'b0;
   logic signed [15:0] req_center_x = '0, req_center_y = '0;
   logic signed [15:0] req_left_x = '0, req_left_y = '0;
   logic signed [15:0] req_right_x = '0, req_right_y = '0;
   logic [16:0]        req_progress = '0;
   logic signed [31:0] req_start_value = '0, req_end_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_curve_value;
   logic               rsp_found;

   piecewise_bezier_easing_eval dut (.*);

   always #5 clock = ~clock;

   // Predictor state
   pbe_pkg::point_type curve_pts [64];
   int         curve_count;
   curve_rsp_type expected_rsps [$];
   curve_req_type pending_reqs [$];

   // Generator shadow, tracks which table entries hold data
   bit gen_written [64];
   int gen_count;
   int gen_items, gen_quiet;
   int n_writes, n_evals, n_found, n_checked, n_errors;
   int cycles;

   function automatic void bern_weights(input longint unsigned t, output longint w[4]);
      longint unsigned s, t2, s2;
      s  = T_ONE - t;
      t2 = (t * t) >> 30;
      s2 = (s * s) >> 30;
      w[0] = longint'((s2 * s) >> 30);
      w[1] = longint'(3 * ((t * s2) >> 30));
      w[2] = longint'(3 * ((t2 * s) >> 30));
      w[3] = longint'((t2 * t) >> 30);
   endfunction

   // Expected curve value for one evaluate transfer
   function automatic curve_rsp_type eval_curve(curve_req_type r);
      curve_rsp_type res;
      longint pr, lo, hi, n, hx1, hx2, dx, x, g, d;
      longint unsigned tl, tr, t;
      longint w[4];
      logic signed [127:0] prod, v;
      pbe_pkg::point_type a, c;
      res.value = '0;
      res.found = 1'b0;
      if (r.prog > UNITY) return res;
      pr = longint'(r.prog) * GRES;
      for (int i = 0; i + 1 < curve_count; i++) begin
         a = curve_pts[i];
         c = curve_pts[i+1];
         lo = longint'(a.cx) * 65536;
         hi = longint'(c.cx) * 65536;
         if (pr < lo || pr > hi) continue;
         n   = (pr - lo) * 16384;
         hx1 = longint'(a.rx) - longint'(a.cx);
         hx2 = longint'(c.lx) - longint'(a.cx);
         dx  = longint'(c.cx) - longint'(a.cx);
         tl = 0;
         tr = T_ONE;
         t  = T_ONE >> 1;
         for (int j = 0; j < STEPS; j++) begin
            bern_weights(t, w);
            x = hx1 * w[1] + hx2 * w[2] + dx * w[3];
            if (n < x) tr = t;
            else tl = t;
            t = (tl + tr) >> 1;
         end
         bern_weights(t, w);
         g = longint'(a.cy) * w[0] + longint'(a.ry) * w[1] +
             longint'(c.ly) * w[2] + longint'(c.cy) * w[3];
         d = longint'(r.ed) - longint'(r.st);
         prod = d * g;
         v = (prod >>> 42) + r.st;
         if (v > 128'sd2147483647) v = 128'sd2147483647;
         if (v < -128'sd2147483648) v = -128'sd2147483648;
         res.value = v[31:0];
         res.found = 1'b1;
         return res;
      end
      return res;
   endfunction

   // Apply one accepted transfer to the predictor
   function automatic void predict_curve_item(curve_req_type r);
      pbe_pkg::point_type p;
      if (r.op == pbe_pkg::OP_WRITE) begin
         p.cx = r.cx; p.cy = r.cy; p.lx = r.lx;
         p.ly = r.ly; p.rx = r.rx; p.ry = r.ry;
         curve_pts[r.idx] = p;
         if (r.last) curve_count = int'(r.idx) + 1;
         n_writes++;
      end else begin
         expected_rsps.push_back(eval_curve(r));
         n_evals++;
      end
   endfunction

   // Gap lengths: mostly none or short, a few long, with quiet stretches
   function automatic int pick_gap(inout int quiet);
      int r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) quiet = $urandom_range(20, 80);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 4);
      return $urandom_range(15, 60);
   endfunction

   function automatic void queue_write(int idx, bit last, int cx, int cy, int lx, int ly,
                                       int rx, int ry);
      curve_req_type r;
      r = '{default: '0};
      r.op = pbe_pkg::OP_WRITE;
      r.idx = idx[5:0];
      r.last = last;
      r.cx = cx[15:0]; r.cy = cy[15:0]; r.lx = lx[15:0];
      r.ly = ly[15:0]; r.rx = rx[15:0]; r.ry = ry[15:0];
      r.prog = 17'($urandom);
      r.st = $urandom;
      r.ed = $urandom;
      r.gap = pick_gap(gen_quiet);
      gen_written[idx] = 1'b1;
      if (last) gen_count = idx + 1;
      pending_reqs.push_back(r);
      gen_items++;
   endfunction

   function automatic void queue_eval(int prog, int st, int ed, bit drain = 0);
      curve_req_type r;
      bit holes;
      r = '{default: '0};
      holes = 1'b0;
      for (int i = 0; i < gen_count; i++)
         if (!gen_written[i]) holes = 1'b1;
      // never read table entries that hold no data: push the ratio past one
      if (holes && gen_count >= 2 && prog <= UNITY) prog = UNITY + 1 + $urandom_range(0, 65534);
      r.op = pbe_pkg::OP_EVAL;
      r.idx = 6'($urandom);
      r.last = 1'($urandom);
      r.cx = 16'($urandom); r.cy = 16'($urandom); r.lx = 16'($urandom);
      r.ly = 16'($urandom); r.rx = 16'($urandom); r.ry = 16'($urandom);
      r.prog = prog[16:0];
      r.st = st;
      r.ed = ed;
      r.gap = pick_gap(gen_quiet);
      r.drain = drain;
      pending_reqs.push_back(r);
      gen_items++;
   endfunction

   function automatic int rand_y(bit wide);
      if (wide) return $signed($urandom_range(0, 65535)) - 32768;
      return $signed($urandom_range(0, 12000)) - 4000;
   endfunction

   // A well-formed curve of n points spread over the unit ratio range
   function automatic void queue_curve(int n);
      int step, cx, jit;
      bit wide;
      step = GRES / (n - 1);
      wide = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n; i++) begin
         jit = (i == 0 || i == n - 1) ? 0 : $signed($urandom_range(0, step / 2)) - step / 4;
         cx = i * step + jit;
         if (i == n - 1 && $urandom_range(0, 3) != 0) cx = GRES;
         if (i == 0 && $urandom_range(0, 5) == 0) cx = -$signed($urandom_range(0, 500));
         if (i > 0 && $urandom_range(0, 15) == 0) cx = (i - 1) * step;
         queue_write(i, i == n - 1, cx, rand_y(wide),
                     cx - $signed($urandom_range(0, step)), rand_y(wide),
                     cx + $signed($urandom_range(0, step)), rand_y(wide));
      end
   endfunction

   function automatic int rand_prog();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return UNITY;
      if (r == 2) return $urandom_range(0, 131071);
      return $urandom_range(0, UNITY);
   endfunction

   function automatic int rand_val(bit wide);
      if (wide) return $urandom;
      return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
   endfunction

   // Input driver
   int  gap_left;
   bit  gap_done;
   curve_req_type cur_req;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         gap_done = 0;
      end else begin
         if (req_valid && req_ready) predict_curve_item(cur_req);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].drain && expected_rsps.size() != 0)) begin
               req_valid <= 1'b0;
            end else if (!gap_done && pending_reqs[0].gap > 0) begin
               gap_left = pending_reqs[0].gap - 1;
               gap_done = 1;
               req_valid <= 1'b0;
            end else begin
               cur_req = pending_reqs.pop_front();
               gap_done = 0;
               req_valid         <= 1'b1;
               req_operation     <= cur_req.op;
               req_point_index   <= cur_req.idx;
               req_is_last_point <= cur_req.last;
               req_center_x      <= cur_req.cx;
               req_center_y      <= cur_req.cy;
               req_left_x        <= cur_req.lx;
               req_left_y        <= cur_req.ly;
               req_right_x       <= cur_req.rx;
               req_right_y       <= cur_req.ry;
               req_progress      <= cur_req.prog;
               req_start_value   <= cur_req.st;
               req_end_value     <= cur_req.ed;
            end
         end
      end
   end

   // Result monitor with random back-pressure
   int stall_left, rsp_quiet;
   curve_rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("ERROR: unexpected result value=%0d found=%0b",
                           rsp_curve_value, rsp_found);
            end else begin
               want = expected_rsps.pop_front();
               n_checked++;
               if (want.found) n_found++;
               if (rsp_curve_value !== want.value || rsp_found !== want.found) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("ERROR: result %0d: value exp %0d got %0d, found exp %0b got %0b",
                              n_checked, want.value, rsp_curve_value, want.found, rsp_found);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            stall_left = pick_gap(rsp_quiet);
            rsp_ready <= (stall_left == 0);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  expected_rsps.size());
         $display("piecewise_bezier_easing_eval regression: fail");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin
      int r;
      // empty table, ratio out of range
      queue_eval(100, 5, 7);
      queue_eval(131071, 0, 100);
      // straight line from (0,0) to (1,1), then extremes of ratio and values
      queue_write(0, 0, 0, 0, 0, 0, 1365, 1365);
      queue_write(1, 1, GRES, GRES, 2731, 2731, GRES, GRES);
      queue_eval(0, 0, 65536, 1);
      queue_eval(UNITY, 0, 65536);
      queue_eval(UNITY + 1, 0, 65536);
      queue_eval(32768, 32'sh8000_0000, 32'sh7fff_ffff);
      queue_eval(12345, 32'sh7fff_ffff, 32'sh8000_0000);
      // extreme coordinates, saturation both ways
      queue_write(0, 0, -32768, 32767, -32768, 32767, 32767, 32767);
      queue_write(1, 1, 32767, -32768, 32767, -32768, -32768, -32768);
      queue_eval(1, 32'sh8000_0000, 32'sh7fff_ffff);
      queue_eval(UNITY, 32'sh7fff_ffff, 32'sh8000_0000);
      queue_eval(40000, -1, 0);
      // segment with equal center x, hit exactly and missed
      queue_write(0, 0, 0, 100, 0, 50, 0, 200);
      queue_write(1, 0, 0, 300, 0, 250, 0, 350);
      queue_write(2, 1, GRES, -400, 3000, -300, GRES, -500);
      queue_eval(0, 1000, -1000);
      queue_eval(16, 1000, -1000);
      // table of a single point, so no segment
      queue_write(0, 1, 2048, 0, 2048, 0, 2048, 0);
      queue_eval(UNITY, 0, 1);

      // random part: mostly whole curves followed by evaluations
      while (gen_items < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            queue_curve(($urandom_range(0, 19) == 0) ? $urandom_range(9, 64)
                                                      : $urandom_range(2, 8));
            repeat ($urandom_range(2, 6))
               queue_eval(rand_prog(), rand_val($urandom_range(0, 3) == 0),
                          rand_val($urandom_range(0, 3) == 0), $urandom_range(0, 30) == 0);
         end else if (r < 75) begin
            queue_write($urandom_range(0, 63), $urandom_range(0, 7) == 0, rand_y(1),
                        rand_y(1), rand_y(1), rand_y(1), rand_y(1), rand_y(1));
         end else begin
            queue_eval(rand_prog(), rand_val(1), rand_val(1), $urandom_range(0, 40) == 0);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d point writes and %0d evaluations; %0d results checked, %0d in a segment",
               n_writes, n_evals, n_checked, n_found);
      if (n_errors == 0 && expected_rsps.size() == 0) begin
         $display("piecewise_bezier_easing_eval regression: pass");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("piecewise_bezier_easing_eval regression: fail");
      end
      $finish;
   end

endmodule
